// File: design/dcq_pkg.sv
// Package with shared constants and codes for the device event coalescing queue.
`timescale 1ns / 1ps
`default_nettype none
package dcq_pkg;
    localparam int QueueDepthDefault = 16;
    localparam int DeviceIdBitsDefault = 16;
    localparam int TypeBits = 3;
    localparam int PortIdBits = 16;
    localparam int OutcomeBits = 3;
    localparam int CountBits = 5;

    localparam logic [TypeBits-1:0] EV_IGNORED      = 3'd0;
    localparam logic [TypeBits-1:0] EV_DEV_ADDED    = 3'd1;
    localparam logic [TypeBits-1:0] EV_DEV_CHANGED  = 3'd2;
    localparam logic [TypeBits-1:0] EV_DEV_REMOVED  = 3'd3;
    localparam logic [TypeBits-1:0] EV_SCANNED      = 3'd4;
    localparam logic [TypeBits-1:0] EV_DISK_ADDED   = 3'd5;
    localparam logic [TypeBits-1:0] EV_DISK_CHANGED = 3'd6;
    localparam logic [TypeBits-1:0] EV_DISK_REMOVED = 3'd7;

    localparam logic [OutcomeBits-1:0] OC_APPENDED  = 3'd0;
    localparam logic [OutcomeBits-1:0] OC_MERGED    = 3'd1;
    localparam logic [OutcomeBits-1:0] OC_CANCELLED = 3'd2;
    localparam logic [OutcomeBits-1:0] OC_FILTERED  = 3'd3;
    localparam logic [OutcomeBits-1:0] OC_REDUNDANT = 3'd4;
    localparam logic [OutcomeBits-1:0] OC_FULL      = 3'd5;
    localparam logic [OutcomeBits-1:0] OC_POPPED    = 3'd6;
    localparam logic [OutcomeBits-1:0] OC_POP_EMPTY = 3'd7;

    localparam logic CMD_POP = 1'b1;
endpackage
`default_nettype wire

// File: design/dcq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/device_event_coalescing_queue_top.sv
// Top level of the device event coalescing queue: control sequencer around one entry RAM.
// Flow: a pop or filtered event passes through the head read, head data and output states,
// where its result is offered. An add scans entries from newest to oldest, then a removal
// shifts newer entries down one by one. One item is in work at a time.
// Reset empties the queue at once; entry contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module device_event_coalescing_queue_top #(
    parameter int QUEUE_DEPTH    = dcq_pkg::QueueDepthDefault,
    parameter int DEVICE_ID_BITS = dcq_pkg::DeviceIdBitsDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // cmd[0], kind[3:1], device_id[19:4]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata   // outcome[2:0], head_valid[3], head_type[6:4],
                                       // head_device[22:7], entry_count[27:23]
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int DW = DEVICE_ID_BITS;
    localparam int TW = dcq_pkg::TypeBits;
    localparam int EW = TW + DW;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SCAN_RD  = 9'b000000010,
        ST_SCAN_CHK = 9'b000000100,
        ST_SH_RD    = 9'b000001000,
        ST_SH_WR    = 9'b000010000,
        ST_APPEND   = 9'b000100000,
        ST_HEAD_RD  = 9'b001000000,
        ST_HEAD_DAT = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [TW-1:0]   type_reg, type_next;
    logic [DW-1:0]   dev_reg, dev_next;
    logic [2:0]      outcome_reg, outcome_next;
    logic            append_reg, append_next;
    logic [31:0]     out_reg, out_next;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;
    logic [TW-1:0]   rd_type;
    logic [DW-1:0]   rd_dev;
    logic [TW-1:0]   in_type;
    logic [DW-1:0]   in_dev;
    logic [DW+15:0]  in_dev_ext;
    logic [DW+15:0]  hd_dev_ext;
    logic [CW+4:0]   cnt_ext;
    logic            related;

    function automatic logic [AW-1:0] qaddr(input logic [AW-1:0] h, input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(h) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    dcq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_entries (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_type    = rdata[EW-1:DW];
    assign rd_dev     = rdata[DW-1:0];
    assign in_type    = s_tdata[3:1];
    assign in_dev_ext = {{DW{1'b0}}, s_tdata[19:4]};
    assign in_dev     = in_dev_ext[DW-1:0];
    assign hd_dev_ext = {16'd0, rd_dev};
    assign cnt_ext    = {5'd0, count_reg};
    assign related    = (rd_dev == dev_reg) && ((rd_type >= dcq_pkg::EV_DISK_ADDED) ==
                        (type_reg >= dcq_pkg::EV_DISK_ADDED));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        type_next    = type_reg;
        dev_next     = dev_reg;
        outcome_next = outcome_reg;
        append_next  = append_reg;
        out_next     = out_reg;
        we           = 1'b0;
        waddr        = qaddr(head_reg, i_reg);
        wdata        = rdata;
        raddr        = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    type_next = in_type;
                    dev_next  = in_dev;
                    k_next    = count_reg;
                    state_next = ST_HEAD_RD;
                    if (s_tdata[0] == dcq_pkg::CMD_POP)
                    begin
                        if (count_reg != '0)
                        begin
                            head_next    = qaddr(head_reg, CW'(1));
                            count_next   = count_reg - CW'(1);
                            outcome_next = dcq_pkg::OC_POPPED;
                        end
                        else
                        begin
                            outcome_next = dcq_pkg::OC_POP_EMPTY;
                        end
                    end
                    else if (in_type == dcq_pkg::EV_IGNORED || in_type == dcq_pkg::EV_SCANNED)
                    begin
                        outcome_next = dcq_pkg::OC_FILTERED;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                raddr = qaddr(head_reg, k_reg - CW'(1));
                if (k_reg != '0)
                begin
                    state_next = ST_SCAN_CHK;
                end
                else if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    outcome_next = dcq_pkg::OC_FULL;
                    state_next   = ST_HEAD_RD;
                end
                else
                begin
                    outcome_next = dcq_pkg::OC_APPENDED;
                    state_next   = ST_APPEND;
                end
            end
            ST_SCAN_CHK:
            begin
                k_next     = k_reg - CW'(1);
                i_next     = k_reg - CW'(1);
                state_next = ST_SCAN_RD;
                if (related)
                begin
                    if (rd_type == type_reg)
                    begin
                        outcome_next = dcq_pkg::OC_MERGED;
                        append_next  = 1'b1;
                        state_next   = ST_SH_RD;
                    end
                    else if (type_reg == dcq_pkg::EV_DEV_REMOVED ||
                             type_reg == dcq_pkg::EV_DISK_REMOVED)
                    begin
                        outcome_next = dcq_pkg::OC_CANCELLED;
                        append_next  = 1'b0;
                        state_next   = ST_SH_RD;
                    end
                    else if (type_reg == dcq_pkg::EV_DISK_CHANGED &&
                             rd_type == dcq_pkg::EV_DISK_ADDED)
                    begin
                        outcome_next = dcq_pkg::OC_REDUNDANT;
                        state_next   = ST_HEAD_RD;
                    end
                end
            end
            ST_SH_RD:
            begin
                raddr = qaddr(head_reg, i_reg + CW'(1));
                if (SW'(i_reg) + SW'(1) < SW'(count_reg))
                begin
                    state_next = ST_SH_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = append_reg ? ST_APPEND : ST_HEAD_RD;
                end
            end
            ST_SH_WR:
            begin
                we         = 1'b1;
                i_next     = i_reg + CW'(1);
                state_next = ST_SH_RD;
            end
            ST_APPEND:
            begin
                we         = 1'b1;
                waddr      = qaddr(head_reg, count_reg);
                wdata      = {type_reg, dev_reg};
                count_next = count_reg + CW'(1);
                state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_DAT;
            end
            ST_HEAD_DAT:
            begin
                out_next = '0;
                out_next[2:0]   = outcome_reg;
                out_next[27:23] = cnt_ext[4:0];
                if (count_reg != '0)
                begin
                    out_next[3]    = 1'b1;
                    out_next[6:4]  = rd_type;
                    out_next[22:7] = hd_dev_ext[15:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        type_reg    <= type_next;
        dev_reg     <= dev_next;
        outcome_reg <= outcome_next;
        append_reg  <= append_next;
        out_reg     <= out_next;
    end
endmodule
`default_nettype wire
